// ===== rtl/core/ibmh_pkg.sv =====
`timescale 1ns / 1ps
package ibmh_pkg;

  localparam int KEY_W    = 32;
  localparam int ITEM_W   = 8;
  localparam int DEPTH    = 256;
  localparam int ADDR_W   = 8;
  localparam int CNT_W    = 9;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = KEY_W + ITEM_W;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DEC    = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_e;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd4;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ITEM_W-1:0]       item;
  } entry_t;

  // one flag per controller step
  typedef struct packed {
    logic accept;
    logic dec_pos;
    logic lk_pos;
    logic lk_key;
    logic pop_eval;
    logic up_rd;
    logic up_eval;
    logic dn_rd;
    logic dn_eval;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  quick;
    logic  up_root;
    logic  up_less;
    logic  dn_move;
    logic  pop_last;
  } stat_t;

  // key first, then item id on a tie
  function automatic logic pair_less(entry_t a, entry_t b);
    logic lt;
    if ($signed(a.key) < $signed(b.key)) lt = 1'b1;
    else if ($signed(b.key) < $signed(a.key)) lt = 1'b0;
    else lt = (a.item < b.item);
    return lt;
  endfunction

endpackage

// ===== rtl/core/indexed_binary_min_heap_unit.sv =====
// Steps: a lookup hit reads the item's position, then its key; errors and a lookup miss
// go straight to the result; push climbs one tree level per read/compare-write pair;
// decrease-key first reads the item's position, then climbs; pop descends one level per pair.
// One operation at a time: a new request is taken only in the idle state, once the last
// result has been loaded into the output register.
// Reset: asynchronous, active low; clears the entry count and every item valid bit at once.
`timescale 1ns / 1ps
module indexed_binary_min_heap_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // key[31:0], item[39:32]
  input  logic [1:0]  s_tuser_i,   // mode[1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [55:0] m_tdata_o,   // out_key[31:0], out_item[39:32], present[40],
                                   // count[49:41], zero pad[55:50]
  output logic [2:0]  m_tuser_o    // status[2:0]
);

  ibmh_pkg::cmd_t   cmd;
  ibmh_pkg::stat_t  stat;
  ibmh_pkg::mode_e  in_mode;

  logic [ibmh_pkg::STATUS_W-1:0]     status;
  logic signed [ibmh_pkg::KEY_W-1:0] out_key;
  logic [ibmh_pkg::ITEM_W-1:0]       out_item;
  logic                              present;
  logic [ibmh_pkg::CNT_W-1:0]        count;

  // Decode the operation carried in the side-band bits
  assign in_mode = ibmh_pkg::mode_e'(s_tuser_i);

  // Sequencer: walks one tree level per read/evaluate pair and holds the
  // finished result until the output register frees up
  ibmh_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Entry memories (two read copies), position table, valid bits, count
  // and the output register
  ibmh_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .in_mode_i  (in_mode),
    .in_key_i   (s_tdata_i[31:0]),
    .in_item_i  (s_tdata_i[39:32]),
    .stat_o     (stat),
    .status_o   (status),
    .out_key_o  (out_key),
    .out_item_o (out_item),
    .present_o  (present),
    .count_o    (count)
  );

  // Pack the result beat
  assign m_tdata_o = {6'b0, count, present, out_item, out_key};
  assign m_tuser_o = status;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> count <= 9'd256)
    else $error("entry count beyond capacity");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && status == ibmh_pkg::ST_EMPTY) |-> count == 9'd0)
    else $error("empty status with entries left");

  a_present_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && present) |-> status == ibmh_pkg::ST_OK)
    else $error("lookup hit with error status");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && status == ibmh_pkg::ST_FULL) |-> count == 9'd256)
    else $error("full status below capacity");
`endif

endmodule

// ===== rtl/core/ibmh_ram.sv =====
`timescale 1ns / 1ps
module ibmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ibmh_dp.sv =====
`timescale 1ns / 1ps
module ibmh_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ibmh_pkg::cmd_t                   cmd_i,
  input  ibmh_pkg::mode_e                  in_mode_i,
  input  logic signed [ibmh_pkg::KEY_W-1:0] in_key_i,
  input  logic [ibmh_pkg::ITEM_W-1:0]      in_item_i,
  output ibmh_pkg::stat_t                  stat_o,
  output logic [ibmh_pkg::STATUS_W-1:0]    status_o,
  output logic signed [ibmh_pkg::KEY_W-1:0] out_key_o,
  output logic [ibmh_pkg::ITEM_W-1:0]      out_item_o,
  output logic                             present_o,
  output logic [ibmh_pkg::CNT_W-1:0]       count_o
);

  localparam int ADDR_W = ibmh_pkg::ADDR_W;
  localparam int CNT_W  = ibmh_pkg::CNT_W;

  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [ibmh_pkg::DEPTH-1:0]  valid_q, valid_d;
  logic [ADDR_W-1:0]           pos_q;
  ibmh_pkg::entry_t            mv_q;

  logic [ibmh_pkg::STATUS_W-1:0]     res_status_q;
  logic signed [ibmh_pkg::KEY_W-1:0] res_key_q;
  logic [ibmh_pkg::ITEM_W-1:0]       res_item_q;
  logic                              res_pres_q;

  logic [ibmh_pkg::STATUS_W-1:0]     out_status_q;
  logic signed [ibmh_pkg::KEY_W-1:0] out_key_q;
  logic [ibmh_pkg::ITEM_W-1:0]       out_item_q;
  logic                              out_pres_q;
  logic [CNT_W-1:0]                  out_cnt_q;

  ibmh_pkg::entry_t  a_rd, b_rd, hw_data, best_e, b1;
  logic [ADDR_W-1:0] pos_rd, a_raddr, b_raddr, hw_addr, par, best_pos;
  logic              hw_en;
  logic [CNT_W:0]    l_idx, r_idx;
  logic              l_ok, r_ok, cl, cr, have, full, empty, quick;
  logic [ibmh_pkg::STATUS_W-1:0] code;

  // Request checks on the incoming beat
  always_comb begin
    have  = valid_q[in_item_i];
    full  = (cnt_q == CNT_W'(ibmh_pkg::DEPTH));
    empty = (cnt_q == '0);
    code  = ibmh_pkg::ST_OK;
    quick = 1'b0;
    unique case (in_mode_i)
      ibmh_pkg::MODE_PUSH: begin
        if (have) begin
          code = ibmh_pkg::ST_PRESENT; quick = 1'b1;
        end else if (full) begin
          code = ibmh_pkg::ST_FULL; quick = 1'b1;
        end
      end
      ibmh_pkg::MODE_POP: begin
        if (empty) begin
          code = ibmh_pkg::ST_EMPTY; quick = 1'b1;
        end
      end
      ibmh_pkg::MODE_DEC: begin
        if (!have) begin
          code = ibmh_pkg::ST_ABSENT; quick = 1'b1;
        end
      end
      ibmh_pkg::MODE_LOOKUP: begin
        quick = !have;
      end
      default: begin
        quick = 1'b1;
      end
    endcase
  end

  // Tree arithmetic
  always_comb begin
    par   = (pos_q - ADDR_W'(1)) >> 1;
    l_idx = {1'b0, pos_q, 1'b1};
    r_idx = l_idx + (CNT_W+1)'(1);
    l_ok  = l_idx < {1'b0, cnt_q};
    r_ok  = r_idx < {1'b0, cnt_q};
    cl    = l_ok && ibmh_pkg::pair_less(a_rd, mv_q);
    b1    = cl ? a_rd : mv_q;
    cr    = r_ok && ibmh_pkg::pair_less(b_rd, b1);
    best_e   = cr ? b_rd : a_rd;
    best_pos = cr ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];
  end

  assign stat_o.mode     = in_mode_i;
  assign stat_o.quick    = quick;
  assign stat_o.up_root  = (pos_q == '0);
  assign stat_o.up_less  = $signed(mv_q.key) < $signed(a_rd.key);
  assign stat_o.dn_move  = cl | cr;
  assign stat_o.pop_last = (cnt_q == CNT_W'(1));

  // Read addresses
  always_comb begin
    if (cmd_i.lk_pos) a_raddr = pos_rd;
    else if (cmd_i.up_rd) a_raddr = par;
    else if (cmd_i.dn_rd) a_raddr = l_idx[ADDR_W-1:0];
    else a_raddr = '0;
    if (cmd_i.dn_rd) b_raddr = r_idx[ADDR_W-1:0];
    else b_raddr = ADDR_W'(cnt_q - CNT_W'(1));
  end

  // At most one heap write per step; the position slot of the written item follows
  always_comb begin
    hw_en   = 1'b0;
    hw_addr = pos_q;
    hw_data = mv_q;
    if (cmd_i.up_rd && stat_o.up_root) begin
      hw_en = 1'b1;
    end else if (cmd_i.up_eval) begin
      hw_en = 1'b1;
      if (stat_o.up_less) hw_data = a_rd;
    end else if (cmd_i.dn_eval) begin
      hw_en = 1'b1;
      if (stat_o.dn_move) hw_data = best_e;
    end
  end

  ibmh_ram #(.WIDTH(ibmh_pkg::ENTRY_W), .DEPTH(ibmh_pkg::DEPTH)) u_heap_a (
    .clk_i, .we_i(hw_en), .waddr_i(hw_addr), .wdata_i(hw_data),
    .raddr_i(a_raddr), .rdata_o(a_rd)
  );

  ibmh_ram #(.WIDTH(ibmh_pkg::ENTRY_W), .DEPTH(ibmh_pkg::DEPTH)) u_heap_b (
    .clk_i, .we_i(hw_en), .waddr_i(hw_addr), .wdata_i(hw_data),
    .raddr_i(b_raddr), .rdata_o(b_rd)
  );

  ibmh_ram #(.WIDTH(ADDR_W), .DEPTH(ibmh_pkg::DEPTH)) u_pos (
    .clk_i, .we_i(hw_en), .waddr_i(hw_data.item), .wdata_i(hw_addr),
    .raddr_i(in_item_i), .rdata_o(pos_rd)
  );

  always_comb begin
    cnt_d   = cnt_q;
    valid_d = valid_q;
    if (cmd_i.accept && in_mode_i == ibmh_pkg::MODE_PUSH && !quick) begin
      valid_d[in_item_i] = 1'b1;
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmd_i.pop_eval) begin
      valid_d[a_rd.item] = 1'b0;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_status_q <= code;
      res_key_q    <= '0;
      res_item_q   <= '0;
      res_pres_q   <= 1'b0;
      mv_q         <= '{key: in_key_i, item: in_item_i};
      pos_q        <= cnt_q[ADDR_W-1:0];
    end
    if (cmd_i.dec_pos) pos_q <= pos_rd;
    if (cmd_i.lk_key) begin
      res_key_q  <= a_rd.key;
      res_pres_q <= 1'b1;
    end
    if (cmd_i.pop_eval) begin
      res_key_q  <= a_rd.key;
      res_item_q <= a_rd.item;
      mv_q       <= b_rd;
      pos_q      <= '0;
    end
    if (cmd_i.up_eval && stat_o.up_less) pos_q <= par;
    if (cmd_i.dn_eval && stat_o.dn_move) pos_q <= best_pos;
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_item_q   <= res_item_q;
      out_pres_q   <= res_pres_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign status_o   = out_status_q;
  assign out_key_o  = out_key_q;
  assign out_item_o = out_item_q;
  assign present_o  = out_pres_q;
  assign count_o    = out_cnt_q;

endmodule

// ===== rtl/core/ibmh_ctrl.sv =====
`timescale 1ns / 1ps
module ibmh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ibmh_pkg::stat_t stat_i,
  output ibmh_pkg::cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DEC_POS  = 10'b0000000010,
    S_LK_POS   = 10'b0000000100,
    S_LK_KEY   = 10'b0000001000,
    S_POP_EVAL = 10'b0000010000,
    S_UP_RD    = 10'b0000100000,
    S_UP_EVAL  = 10'b0001000000,
    S_DN_RD    = 10'b0010000000,
    S_DN_EVAL  = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d, slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.dec_pos  = (state_q == S_DEC_POS);
    cmd_o.lk_pos   = (state_q == S_LK_POS);
    cmd_o.lk_key   = (state_q == S_LK_KEY);
    cmd_o.pop_eval = (state_q == S_POP_EVAL);
    cmd_o.up_rd    = (state_q == S_UP_RD);
    cmd_o.up_eval  = (state_q == S_UP_EVAL);
    cmd_o.dn_rd    = (state_q == S_DN_RD);
    cmd_o.dn_eval  = (state_q == S_DN_EVAL);
    cmd_o.out_load = (state_q == S_DONE) && slot_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.quick) state_d = S_DONE;
          else begin
            unique case (stat_i.mode)
              ibmh_pkg::MODE_PUSH:   state_d = S_UP_RD;
              ibmh_pkg::MODE_POP:    state_d = S_POP_EVAL;
              ibmh_pkg::MODE_DEC:    state_d = S_DEC_POS;
              ibmh_pkg::MODE_LOOKUP: state_d = S_LK_POS;
              default:               state_d = S_DONE;
            endcase
          end
        end
      end
      S_DEC_POS:  state_d = S_UP_RD;
      S_LK_POS:   state_d = S_LK_KEY;
      S_LK_KEY:   state_d = S_DONE;
      S_POP_EVAL: state_d = stat_i.pop_last ? S_DONE : S_DN_RD;
      S_UP_RD:    state_d = stat_i.up_root ? S_DONE : S_UP_EVAL;
      S_UP_EVAL:  state_d = stat_i.up_less ? S_UP_RD : S_DONE;
      S_DN_RD:    state_d = S_DN_EVAL;
      S_DN_EVAL:  state_d = stat_i.dn_move ? S_DN_RD : S_DONE;
      S_DONE: begin
        if (slot_free) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
